// File: hdl/ordered_list_engine_top_defines.svh
// Assertion macros used by the ordered list engine datapath.
`ifndef ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`define ORDERED_LIST_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define OLE_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ordered list engine: same-cycle check failed");
// next-cycle implication
`define OLE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ordered list engine: next-cycle check failed");
`else
`define OLE_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define OLE_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

// File: hdl/ole_pkg.sv
// Package: types, command codes and defaults for the ordered list engine.
`default_nettype none
package ole_pkg;

    localparam int OLE_CAPACITY   = 256;
    localparam int OLE_ITEM_WIDTH = 32;

    typedef enum logic [3:0] {
        OP_APPEND       = 4'd0,
        OP_INSERT       = 4'd1,
        OP_REMOVE_AT    = 4'd2,
        OP_REMOVE_VALUE = 4'd3,
        OP_REMOVE_RUN   = 4'd4,
        OP_FIND         = 4'd5,
        OP_READ_AT      = 4'd6,
        OP_FIRST        = 4'd7,
        OP_LAST         = 4'd8,
        OP_CLEAR        = 4'd9
    } op_t;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] item_value;
        logic [7:0]  position;
        logic [8:0]  amount;
    } in_beat_t;

    typedef struct packed {
        logic        ok;
        logic [7:0]  found_index;
        logic [31:0] item_out;
        logic [8:0]  length;
        logic        empty_res;
    } res_beat_t;

    // controller -> datapath strobes
    typedef struct packed {
        logic load;
        logic decode;
        logic scan_start;
        logic scan_step;
        logic move_up_start;
        logic move_dn_start;
        logic move_step;
        logic put;
        logic read_issue;
        logic read_capture;
        logic commit;
        logic clear;
        logic push;
    } ctrl_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic [3:0] cmd;
        logic       legal;
        logic       scan_hit;
        logic       scan_end;
        logic       move_busy;
        logic       out_free;
    } dp_sts_t;

endpackage
`default_nettype wire

// File: hdl/ordered_list_engine_top.sv
// Ordered list engine: one list command per input beat, one result beat per command.
//   s_ channel: command beat (cmd, item_value, position, amount), valid/ready.
//   m_ channel: result beat (ok, found_index, item_out, length, empty_res), valid/ready.
// Items sit in a single RAM of CAPACITY words with one write and one registered read
// port. Commands run one at a time; s_ready is high only while the sequencer is idle.
// Steps per command: clear and failed commands go from decode to the result; append
// writes at the tail; read, first and last issue one RAM read and capture it; insert
// shifts the entries from position up, then writes; remove_at reads the entry, then
// shifts the tail down over it; remove_run shifts the tail down over the run; find and
// remove_value scan one entry per cycle, plus the shift for a removal. The shift and
// scan loops move one entry per cycle, bounded by the single RAM read port.
// The result sits in an output register, so the next command is accepted while it waits.
// If the receiver stalls and a second result is ready, the sequencer holds it until
// the output register frees up.
// Reset (aresetn low, synchronous) empties the list; no RAM clearing pass is needed.
`default_nettype none
module ordered_list_engine_top #(
    parameter int CAPACITY   = ole_pkg::OLE_CAPACITY,
    parameter int ITEM_WIDTH = ole_pkg::OLE_ITEM_WIDTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ole_pkg::in_beat_t   s_payload,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ole_pkg::res_beat_t       m_payload
);
    import ole_pkg::*;

    ctrl_cmd_t ctrl;
    dp_sts_t   sts;

    ole_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctrl    (ctrl)
    );

    ole_datapath #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .ctrl      (ctrl),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );
endmodule
`default_nettype wire

// File: hdl/ole_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// File: hdl/ole_ctrl.sv
// Command sequencer for the ordered list engine.
`default_nettype none
module ole_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ole_pkg::dp_sts_t    sts,
    output ole_pkg::ctrl_cmd_t       ctrl
);
    import ole_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_DECODE  = 8'b0000_0010,
        ST_SCAN    = 8'b0000_0100,
        ST_MOVE    = 8'b0000_1000,
        ST_PUT     = 8'b0001_0000,
        ST_CAPTURE = 8'b0010_0000,
        ST_DONE    = 8'b0100_0000,
        ST_READ    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctrl.load  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                ctrl.decode = 1'b1;
                if (!sts.legal) begin
                    state_next = ST_DONE;
                end else begin
                    unique case (sts.cmd)
                        OP_APPEND: state_next = ST_PUT;
                        OP_INSERT: begin
                            ctrl.move_up_start = 1'b1;
                            state_next         = ST_MOVE;
                        end
                        OP_REMOVE_AT, OP_READ_AT, OP_FIRST, OP_LAST: begin
                            state_next = ST_READ;
                        end
                        OP_REMOVE_VALUE, OP_FIND: begin
                            ctrl.scan_start = 1'b1;
                            state_next      = ST_SCAN;
                        end
                        OP_REMOVE_RUN: begin
                            ctrl.move_dn_start = 1'b1;
                            state_next         = ST_MOVE;
                        end
                        OP_CLEAR: begin
                            ctrl.clear = 1'b1;
                            state_next = ST_DONE;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ: begin
                ctrl.read_issue = 1'b1;
                state_next      = ST_CAPTURE;
            end
            ST_CAPTURE: begin
                ctrl.read_capture = 1'b1;
                if (sts.cmd == OP_REMOVE_AT) begin
                    ctrl.move_dn_start = 1'b1;
                    state_next         = ST_MOVE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                ctrl.scan_step = 1'b1;
                if (sts.scan_hit) begin
                    if (sts.cmd == OP_REMOVE_VALUE) begin
                        ctrl.move_dn_start = 1'b1;
                        state_next         = ST_MOVE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else if (sts.scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_MOVE: begin
                ctrl.move_step = 1'b1;
                if (!sts.move_busy) begin
                    if (sts.cmd == OP_INSERT) begin
                        state_next = ST_PUT;
                    end else begin
                        ctrl.commit = 1'b1;
                        state_next  = ST_DONE;
                    end
                end
            end
            ST_PUT: begin
                ctrl.put   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    ctrl.push  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

// File: hdl/ole_datapath.sv
// Datapath: command registers, list length, scan and shift pointers, result register.
`default_nettype none
`include "ordered_list_engine_top_defines.svh"
module ole_datapath #(
    parameter int CAPACITY   = ole_pkg::OLE_CAPACITY,
    parameter int ITEM_WIDTH = ole_pkg::OLE_ITEM_WIDTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ole_pkg::in_beat_t   s_payload,
    input  wire ole_pkg::ctrl_cmd_t  ctrl,
    output ole_pkg::dp_sts_t         sts,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ole_pkg::res_beat_t       m_payload
);
    import ole_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = CW + 9;

    // command beat
    logic [3:0]            cmd_reg;
    logic [ITEM_WIDTH-1:0] val_reg;
    logic [7:0]            pos_reg;
    logic [8:0]            amt_reg;
    // result fields under construction
    logic                  ok_reg;
    logic [7:0]            fidx_reg;
    logic [ITEM_WIDTH-1:0] item_reg;
    // list state and walkers
    logic [CW-1:0]         filled_reg;
    logic [CW-1:0]         gap_reg;
    logic [CW-1:0]         scan_ptr_reg;
    logic [AW-1:0]         scan_idx_reg;
    logic                  scan_pend_reg;
    logic [AW-1:0]         src_reg;
    logic [AW-1:0]         dst_reg;
    logic [CW-1:0]         mv_rem_reg;
    logic                  mv_pend_reg;
    logic                  dir_up_reg;
    logic                  m_valid_reg;
    res_beat_t             res_reg;

    logic                  ram_wr_en, ram_rd_en;
    logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
    logic [ITEM_WIDTH-1:0] ram_wr_data, rd_data;

    logic [WW-1:0] f_w, pos_w, amt_w, cap_w, idx_w, fm1_w;
    logic [WW-1:0] rest_w, run_w, base_w, dn_src_w, dn_rem_w;
    logic          legal, scan_issue, scan_hit, mv_active, out_free, is_scan_op;
    logic [ITEM_WIDTH+31:0] in_val_ext;
    logic [ITEM_WIDTH+31:0] item_ext;
    logic [AW+7:0]          idx_ext;
    logic [CW+8:0]          f_ext;
    logic [AW-1:0]          rd_pick, put_addr;

    assign in_val_ext = {{ITEM_WIDTH{1'b0}}, s_payload.item_value};
    assign item_ext   = {32'd0, item_reg};
    assign idx_ext    = {8'd0, scan_idx_reg};
    assign f_ext      = {9'd0, filled_reg};

    assign f_w      = WW'(filled_reg);
    assign pos_w    = WW'(pos_reg);
    assign amt_w    = WW'(amt_reg);
    assign cap_w    = WW'(CAPACITY);
    assign idx_w    = WW'(scan_idx_reg);
    assign fm1_w    = f_w - WW'(1);
    assign rest_w   = f_w - pos_w;
    assign run_w    = (amt_w < rest_w) ? amt_w : rest_w;
    assign base_w   = (cmd_reg == OP_REMOVE_VALUE) ? idx_w : pos_w;
    // a run removal starts its shift at decode, before gap_reg is loaded
    assign dn_src_w = base_w + ((cmd_reg == OP_REMOVE_RUN) ? run_w : WW'(gap_reg));
    assign dn_rem_w = f_w - dn_src_w;

    assign is_scan_op = (cmd_reg == OP_FIND) || (cmd_reg == OP_REMOVE_VALUE);

    always_comb begin
        unique case (cmd_reg)
            OP_APPEND:                              legal = (f_w < cap_w);
            OP_INSERT:                              legal = (f_w < cap_w) && (pos_w <= f_w);
            OP_REMOVE_AT, OP_READ_AT, OP_REMOVE_RUN: legal = (pos_w < f_w);
            OP_REMOVE_VALUE, OP_FIND, OP_CLEAR:     legal = 1'b1;
            OP_FIRST, OP_LAST:                      legal = (filled_reg != '0);
            default:                                legal = 1'b0;
        endcase
    end

    assign scan_issue = (scan_ptr_reg < filled_reg);
    assign scan_hit   = scan_pend_reg && (rd_data == val_reg);
    assign mv_active  = (mv_rem_reg != '0);
    assign out_free   = !m_valid_reg || m_ready;

    assign sts.cmd       = cmd_reg;
    assign sts.legal     = legal;
    assign sts.scan_hit  = scan_hit;
    assign sts.scan_end  = !scan_pend_reg && !scan_issue;
    assign sts.move_busy = mv_active || mv_pend_reg;
    assign sts.out_free  = out_free;

    assign rd_pick  = (cmd_reg == OP_FIRST) ? '0 :
                      (cmd_reg == OP_LAST)  ? fm1_w[AW-1:0] : pos_w[AW-1:0];
    assign put_addr = (cmd_reg == OP_APPEND) ? f_w[AW-1:0] : pos_w[AW-1:0];

    // one RAM read and one RAM write per cycle at most
    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = val_reg;
        if (ctrl.scan_step && scan_issue) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = scan_ptr_reg[AW-1:0];
        end
        if (ctrl.move_step && mv_active) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = src_reg;
        end
        if (ctrl.read_issue) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = rd_pick;
        end
        if (ctrl.move_step && mv_pend_reg) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = dst_reg;
            ram_wr_data = rd_data;
        end
        if (ctrl.put) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = put_addr;
        end
    end

    ole_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg    <= '0;
            scan_pend_reg <= 1'b0;
            mv_rem_reg    <= '0;
            mv_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (ctrl.clear) begin
                filled_reg <= '0;
            end else if (ctrl.put) begin
                filled_reg <= filled_reg + CW'(1);
            end else if (ctrl.commit) begin
                filled_reg <= filled_reg - gap_reg;
            end

            if (ctrl.scan_start) begin
                scan_pend_reg <= 1'b0;
            end else if (ctrl.scan_step) begin
                scan_pend_reg <= scan_issue;
            end

            if (ctrl.move_up_start) begin
                mv_rem_reg <= rest_w[CW-1:0];
            end else if (ctrl.move_dn_start) begin
                mv_rem_reg <= dn_rem_w[CW-1:0];
            end else if (ctrl.move_step && mv_active) begin
                mv_rem_reg <= mv_rem_reg - CW'(1);
            end

            if (ctrl.move_up_start || ctrl.move_dn_start) begin
                mv_pend_reg <= 1'b0;
            end else if (ctrl.move_step) begin
                mv_pend_reg <= mv_active;
            end

            if (ctrl.push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg  <= s_payload.cmd;
            val_reg  <= in_val_ext[ITEM_WIDTH-1:0];
            pos_reg  <= s_payload.position;
            amt_reg  <= s_payload.amount;
            ok_reg   <= 1'b0;
            fidx_reg <= '0;
            item_reg <= '0;
        end
        if (ctrl.decode) begin
            ok_reg  <= legal && !is_scan_op;
            gap_reg <= (cmd_reg == OP_REMOVE_RUN) ? run_w[CW-1:0] : CW'(1);
        end
        if (ctrl.scan_start) begin
            scan_ptr_reg <= '0;
        end
        if (ctrl.scan_step) begin
            if (scan_issue) begin
                scan_ptr_reg <= scan_ptr_reg + CW'(1);
                scan_idx_reg <= scan_ptr_reg[AW-1:0];
            end
            if (scan_hit) begin
                ok_reg <= 1'b1;
                if (cmd_reg == OP_FIND) begin
                    fidx_reg <= idx_ext[7:0];
                end
                if (cmd_reg == OP_REMOVE_VALUE) begin
                    item_reg <= val_reg;
                end
            end
        end
        if (ctrl.read_capture) begin
            item_reg <= rd_data;
        end
        // up: walk from the tail towards the position; down: close the gap
        if (ctrl.move_up_start) begin
            src_reg    <= fm1_w[AW-1:0];
            dst_reg    <= f_w[AW-1:0];
            dir_up_reg <= 1'b1;
        end else if (ctrl.move_dn_start) begin
            src_reg    <= dn_src_w[AW-1:0];
            dst_reg    <= base_w[AW-1:0];
            dir_up_reg <= 1'b0;
        end else if (ctrl.move_step) begin
            if (mv_active) begin
                src_reg <= dir_up_reg ? src_reg - AW'(1) : src_reg + AW'(1);
            end
            if (mv_pend_reg) begin
                dst_reg <= dir_up_reg ? dst_reg - AW'(1) : dst_reg + AW'(1);
            end
        end
        if (ctrl.push) begin
            res_reg.ok          <= ok_reg;
            res_reg.found_index <= fidx_reg;
            res_reg.item_out    <= item_ext[31:0];
            res_reg.length      <= f_ext[8:0];
            res_reg.empty_res   <= (filled_reg == '0);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = res_reg;

    `OLE_ASSERT_IMPL(a_fill_bound, aclk, aresetn, 1'b1, filled_reg <= CW'(CAPACITY))
    `OLE_ASSERT_IMPL(a_no_rw_clash, aclk, aresetn, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr)
    `OLE_ASSERT_IMPL(a_push_free, aclk, aresetn, ctrl.push, !m_valid_reg || m_ready)
    `OLE_ASSERT_NEXT(a_put_grows, aclk, aresetn, ctrl.put, filled_reg == $past(filled_reg) + CW'(1))
endmodule
`default_nettype wire
